// ===== hdl/gef_pkg.sv =====
`timescale 1ns / 1ps
package gef_pkg;

  localparam int GLYPH_W             = 32;
  localparam int LEN_W               = 3;
  localparam int ENTRY_W             = 4;
  localparam int PAIR_ENTRIES_DEF    = 16;
  localparam int ILLEGAL_ENTRIES_DEF = 16;
  localparam int CMD_DEPTH           = 2;

  localparam logic [1:0] FN_ENCODE  = 2'd0;
  localparam logic [1:0] FN_PAIR    = 2'd1;
  localparam logic [1:0] FN_ILLEGAL = 2'd2;
  localparam logic [1:0] FN_CLEAR   = 2'd3;

  localparam logic [7:0] CHAR_PCT = 8'h25;
  localparam logic [7:0] CHAR_0   = 8'h30;
  localparam logic [7:0] CHAR_A   = 8'h41;
  localparam logic [3:0] HEX_TEN  = 4'd10;

  localparam logic [LEN_W-1:0] LEN_MIN = 3'd1;
  localparam logic [LEN_W-1:0] LEN_MAX = 3'd4;

  typedef struct packed {
    logic [1:0]         func;
    logic [GLYPH_W-1:0] glyph;
    logic [LEN_W-1:0]   glyph_len;
    logic [GLYPH_W-1:0] paired_glyph;
    logic [LEN_W-1:0]   paired_len;
    logic [ENTRY_W-1:0] entry_index;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_t;

  // Normalized glyph: clamped length, bytes past the length zeroed.
  typedef struct packed {
    logic [LEN_W-1:0]   len;
    logic [GLYPH_W-1:0] bytes;
  } key_t;

  localparam int KEY_W = $bits(key_t);

  localparam key_t PCT_KEY = '{len: LEN_MIN, bytes: {24'h000000, CHAR_PCT}};

  typedef enum logic [1:0] {
    CMD_RAW,
    CMD_ESC,
    CMD_PCT
  } cmd_mode_t;

  typedef struct packed {
    cmd_mode_t mode;
    key_t      key;
  } cmd_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_MATCH,
    FR_PICK,
    FR_CHECK
  } front_state_t;

  function automatic key_t make_key(logic [GLYPH_W-1:0] g, logic [LEN_W-1:0] l);
    key_t             k;
    logic [LEN_W-1:0] n;
    n = (l < LEN_MIN) ? LEN_MIN : ((l > LEN_MAX) ? LEN_MAX : l);
    k.len = n;
    for (int b = 0; b < 4; b++) begin
      k.bytes[8*b +: 8] = (LEN_W'(b) < n) ? g[8*b +: 8] : 8'h00;
    end
    return k;
  endfunction

  function automatic logic [7:0] hex_digit(logic [3:0] d);
    logic [7:0] r;
    if (d < HEX_TEN) begin
      r = CHAR_0 + {4'h0, d};
    end else begin
      r = CHAR_A + {4'h0, d} - {4'h0, HEX_TEN};
    end
    return r;
  endfunction

endpackage

// ===== hdl/glyph_escape_filename_encoder.sv =====
`timescale 1ns / 1ps
// Filename encoder for UTF-8 glyphs, one glyph per input transfer.
// Input queue side: in_push / in_full / in_data. func selects encode, load
// of a substitution pair, load of an illegal glyph, or clear of all valid
// bits. Load and clear give no output.
// Output queue side: out_empty / out_pop / out_data. Each encode yields 1 to
// 12 byte transfers; last marks the final byte of the glyph.
// The first byte of an encode passes the lookup steps (match, pick,
// classify), the command queue, the command load and the output register
// on its way to out_data.
// Throughput: the front takes no new item until the lookup has handed its
// glyph to the command queue; the emitter gives one byte per cycle unless
// out_pop stalls it, so it limits escapes (3 bytes per glyph byte).
// A two-entry command queue sits between lookup and emitter, so the front
// keeps accepting while the output side is stalled, until that queue fills.
// When the receiver holds out_pop low, the waiting byte stays on out_data
// and the emitter stops.
// Reset clears all table valid bits, the command queue, the lookup and the
// output register; table contents stay undefined, never read before a load.
module glyph_escape_filename_encoder #(
  parameter int PAIR_ENTRIES    = gef_pkg::PAIR_ENTRIES_DEF,
  parameter int ILLEGAL_ENTRIES = gef_pkg::ILLEGAL_ENTRIES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  input  gef_pkg::in_t  in_data,
  output logic          in_full,
  output logic          out_empty,
  input  logic          out_pop,
  output gef_pkg::out_t out_data
);
  import gef_pkg::*;

  // Commands from lookup to emitter
  logic cmd_push;
  logic cmd_full;
  logic cmd_pop;
  logic cmd_empty;
  cmd_t cmd_wr;
  cmd_t cmd_rd;

  // Front: accept items, update tables, classify each glyph
  gef_front #(
    .PAIR_ENTRIES    (PAIR_ENTRIES),
    .ILLEGAL_ENTRIES (ILLEGAL_ENTRIES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .cmd_push (cmd_push),
    .cmd_data (cmd_wr),
    .cmd_full (cmd_full)
  );

  // Decouple lookup from byte emission
  gef_cmd_fifo u_cmd_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (cmd_push),
    .wr_data (cmd_wr),
    .full    (cmd_full),
    .pop     (cmd_pop),
    .rd_data (cmd_rd),
    .empty   (cmd_empty)
  );

  // Back: emit one filename byte per cycle into the output register unless out_pop stalls it
  gef_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd_data  (cmd_rd),
    .cmd_pop   (cmd_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

// ===== hdl/gef_cmd_fifo.sv =====
`timescale 1ns / 1ps
module gef_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  gef_pkg::cmd_t wr_data,
  output logic          full,
  input  logic          pop,
  output gef_pkg::cmd_t rd_data,
  output logic          empty
);
  import gef_pkg::*;

  localparam int PTR_W = $clog2(CMD_DEPTH);
  localparam int CNT_W = $clog2(CMD_DEPTH + 1);

  cmd_t             mem_r [CMD_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == CNT_W'(CMD_DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("command queue written while full");

endmodule

// ===== hdl/gef_front.sv =====
`timescale 1ns / 1ps
module gef_front #(
  parameter int PAIR_ENTRIES    = gef_pkg::PAIR_ENTRIES_DEF,
  parameter int ILLEGAL_ENTRIES = gef_pkg::ILLEGAL_ENTRIES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  input  gef_pkg::in_t  in_data,
  output logic          in_full,
  output logic          cmd_push,
  output gef_pkg::cmd_t cmd_data,
  input  logic          cmd_full
);
  import gef_pkg::*;

  localparam int PCW = ENTRY_W + $clog2(PAIR_ENTRIES + 1);
  localparam int ICW = ENTRY_W + $clog2(ILLEGAL_ENTRIES + 1);

  key_t src_tab_r [PAIR_ENTRIES];
  key_t tgt_tab_r [PAIR_ENTRIES];
  key_t ill_tab_r [ILLEGAL_ENTRIES];

  logic [PAIR_ENTRIES-1:0]    pair_valid_r;
  logic [ILLEGAL_ENTRIES-1:0] ill_valid_r;

  front_state_t state_r, state_nxt;

  key_t                       key_r;
  key_t                       tkey_r;
  logic                       trans_r;
  logic [PAIR_ENTRIES-1:0]    src_hit_r;
  logic [PAIR_ENTRIES-1:0]    tgt_hit_r;
  logic [ILLEGAL_ENTRIES-1:0] ill_hit_r;

  logic                       accept;
  key_t                       in_key;
  key_t                       pair_key;
  logic [PAIR_ENTRIES-1:0]    src_first;
  logic [KEY_W-1:0]           tkey_acc;
  logic [ILLEGAL_ENTRIES-1:0] tkey_ill_vec;
  logic                       tkey_ill;
  logic                       is_pct;
  logic                       do_esc;

  assign in_full  = (state_r != FR_IDLE);
  assign accept   = in_push && !in_full;
  assign in_key   = make_key(in_data.glyph, in_data.glyph_len);
  assign pair_key = make_key(in_data.paired_glyph, in_data.paired_len);

  // Table contents: no reset, only valid bits matter.
  always_ff @(posedge clk) begin
    for (int i = 0; i < PAIR_ENTRIES; i++) begin
      if (accept && in_data.func == FN_PAIR && PCW'(in_data.entry_index) == PCW'(i)) begin
        src_tab_r[i] <= in_key;
        tgt_tab_r[i] <= pair_key;
      end
    end
    for (int i = 0; i < ILLEGAL_ENTRIES; i++) begin
      if (accept && in_data.func == FN_ILLEGAL &&
          ICW'(in_data.entry_index) == ICW'(i)) begin
        ill_tab_r[i] <= in_key;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_valid_r <= '0;
      ill_valid_r  <= '0;
    end else if (accept) begin
      unique case (in_data.func)
        FN_PAIR: begin
          for (int i = 0; i < PAIR_ENTRIES; i++) begin
            if (PCW'(in_data.entry_index) == PCW'(i)) pair_valid_r[i] <= 1'b1;
          end
        end
        FN_ILLEGAL: begin
          for (int i = 0; i < ILLEGAL_ENTRIES; i++) begin
            if (ICW'(in_data.entry_index) == ICW'(i)) ill_valid_r[i] <= 1'b1;
          end
        end
        FN_CLEAR: begin
          pair_valid_r <= '0;
          ill_valid_r  <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Lowest matching source entry wins.
  assign src_first = src_hit_r & (~src_hit_r + 1'b1);

  always_comb begin
    tkey_acc = '0;
    for (int i = 0; i < PAIR_ENTRIES; i++) begin
      if (src_first[i]) tkey_acc = tkey_acc | tgt_tab_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_r <= in_key;
    end
    if (state_r == FR_MATCH) begin
      for (int i = 0; i < PAIR_ENTRIES; i++) begin
        src_hit_r[i] <= pair_valid_r[i] && (src_tab_r[i] == key_r);
        tgt_hit_r[i] <= pair_valid_r[i] && (tgt_tab_r[i] == key_r);
      end
      for (int i = 0; i < ILLEGAL_ENTRIES; i++) begin
        ill_hit_r[i] <= ill_valid_r[i] && (ill_tab_r[i] == key_r);
      end
    end
    if (state_r == FR_PICK) begin
      tkey_r  <= key_t'(tkey_acc);
      trans_r <= |src_hit_r;
    end
  end

  // Classify: translated glyphs check the illegal set and the percent glyph again.
  always_comb begin
    for (int i = 0; i < ILLEGAL_ENTRIES; i++) begin
      tkey_ill_vec[i] = ill_valid_r[i] && (ill_tab_r[i] == tkey_r);
    end
    tkey_ill = (tkey_r == PCT_KEY) || (|tkey_ill_vec);
    is_pct   = !trans_r && (key_r.bytes[7:0] == CHAR_PCT);
    do_esc   = trans_r ? tkey_ill : ((|ill_hit_r) || (|tgt_hit_r));
    if (is_pct) begin
      cmd_data.mode = CMD_PCT;
    end else if (do_esc) begin
      cmd_data.mode = CMD_ESC;
    end else begin
      cmd_data.mode = CMD_RAW;
    end
    cmd_data.key = (trans_r && !do_esc) ? tkey_r : key_r;
  end

  assign cmd_push = (state_r == FR_CHECK) && !cmd_full;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FR_IDLE:  if (accept && in_data.func == FN_ENCODE) state_nxt = FR_MATCH;
      FR_MATCH: state_nxt = FR_PICK;
      FR_PICK:  state_nxt = FR_CHECK;
      FR_CHECK: if (!cmd_full) state_nxt = FR_IDLE;
      default:  state_nxt = FR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FR_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_clear_drops_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.func == FN_CLEAR) |=> (pair_valid_r == '0 && ill_valid_r == '0))
    else $error("clear left a valid bit set");

  a_lookup_sequence: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FR_MATCH) |-> ##2 (state_r == FR_CHECK))
    else $error("lookup did not reach the classify step");

endmodule

// ===== hdl/gef_back.sv =====
`timescale 1ns / 1ps
module gef_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_empty,
  input  gef_pkg::cmd_t cmd_data,
  output logic          cmd_pop,
  output logic          out_empty,
  input  logic          out_pop,
  output gef_pkg::out_t out_data
);
  import gef_pkg::*;

  logic       busy_r, busy_nxt;
  cmd_mode_t  mode_r;
  key_t       key_r;
  logic [1:0] bidx_r, bidx_nxt;
  logic [1:0] phase_r, phase_nxt;
  out_t       out_r;
  logic       out_valid_r, out_valid_nxt;

  logic             adv;
  logic             emit;
  logic             take;
  logic [7:0]       emit_byte;
  logic             emit_last;
  logic [7:0]       cur_byte;
  logic [LEN_W-1:0] len_m1;
  logic             at_last_byte;

  assign adv          = !out_valid_r || out_pop;
  assign emit         = busy_r && adv;
  assign take         = !cmd_empty && (!busy_r || (emit && emit_last));
  assign cmd_pop      = take;
  assign cur_byte     = key_r.bytes[{bidx_r, 3'b000} +: 8];
  assign len_m1       = key_r.len - 3'd1;
  assign at_last_byte = ({1'b0, bidx_r} == len_m1);

  always_comb begin
    emit_byte = cur_byte;
    emit_last = at_last_byte;
    unique case (mode_r)
      CMD_PCT: begin
        emit_byte = CHAR_PCT;
        emit_last = (phase_r == 2'd1);
      end
      CMD_ESC: begin
        case (phase_r)
          2'd0:    emit_byte = CHAR_PCT;
          2'd1:    emit_byte = hex_digit(cur_byte[7:4]);
          default: emit_byte = hex_digit(cur_byte[3:0]);
        endcase
        emit_last = (phase_r == 2'd2) && at_last_byte;
      end
      CMD_RAW: begin
        emit_byte = cur_byte;
        emit_last = at_last_byte;
      end
      default: begin
        emit_byte = cur_byte;
        emit_last = 1'b1;
      end
    endcase
  end

  always_comb begin
    busy_nxt  = busy_r;
    bidx_nxt  = bidx_r;
    phase_nxt = phase_r;
    if (take) begin
      busy_nxt  = 1'b1;
      bidx_nxt  = '0;
      phase_nxt = '0;
    end else if (emit) begin
      if (emit_last) begin
        busy_nxt = 1'b0;
      end else begin
        case (mode_r)
          CMD_ESC: begin
            if (phase_r == 2'd2) begin
              phase_nxt = '0;
              bidx_nxt  = bidx_r + 1'b1;
            end else begin
              phase_nxt = phase_r + 1'b1;
            end
          end
          CMD_PCT: phase_nxt = phase_r + 1'b1;
          default: bidx_nxt = bidx_r + 1'b1;
        endcase
      end
    end
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      bidx_r      <= '0;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      bidx_r      <= bidx_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      mode_r <= cmd_data.mode;
      key_r  <= cmd_data.key;
    end
    if (emit) begin
      out_r.out_byte <= emit_byte;
      out_r.last     <= emit_last;
    end
  end

  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

  a_byte_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> ({1'b0, bidx_r} < key_r.len))
    else $error("byte index ran past glyph length");

  a_phase_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && mode_r == CMD_RAW) |-> (phase_r == 2'd0))
    else $error("plain glyph stepped the escape phase");

endmodule
